[rtl/tsp_pkg.sv]
`default_nettype none
package tsp_pkg;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_FILE   = 3'd1,
    PH_DIR    = 3'd2,
    PH_PAD    = 3'd3,
    PH_DONE   = 3'd4,
    PH_ERROR  = 3'd5
  } phase_t;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_CHECKSUM = 3'd1;
  localparam logic [2:0] ERR_PATH     = 3'd2;
  localparam logic [2:0] ERR_TYPE     = 3'd3;
  localparam logic [2:0] ERR_TRUNC    = 3'd4;

  localparam logic [1:0] ET_FILE    = 2'd0;
  localparam logic [1:0] ET_DIR     = 2'd1;
  localparam logic [1:0] ET_SYMLINK = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_FIVE  = 8'h35;

  localparam int OUT_SIZE_W = 36;

  // Path checker flags.
  typedef struct packed {
    logic pre_slash;
    logic pre_set;
    logic dotdot;
    logic name_slash;
    logic name_empty;
    logic ended;
    logic slash3;
  } path_flags_t;

  // Header summary handed to the result stage at the last header byte.
  typedef struct packed {
    logic        all_zero;
    logic        sum_ok;
    logic        unsafe;
    logic [7:0]  type_byte;
    logic [11:0] mode;
  } hdr_sum_t;

endpackage
`default_nettype wire

[rtl/tar_stream_parser.sv]
`default_nettype none
// Ustar archive parser taking one archive byte per beat, one beat per cycle
// sustained. Each beat is decoded by the header accumulators and the phase
// sequencer in the cycle it is accepted, and yields at most one result beat,
// which appears in a one-entry output register in the cycle after the accept.
// The input stalls only while that register is full and the output side
// stalls. Results are file data bytes (with a last mark), entry headers, end
// of archive, or a sticky error. SIZE_BITS sets the width of the parsed size
// field.
module tar_stream_parser
  import tsp_pkg::*;
#(
  parameter int SIZE_BITS = 36
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_op,
  input  wire logic [7:0]  in_in_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_out_byte,
  output logic             out_last_of_file,
  output logic [1:0]       out_entry_type,
  output logic [OUT_SIZE_W-1:0] out_entry_size,
  output logic [11:0]      out_entry_mode,
  output logic [2:0]       out_error_code
);

  phase_t               phase_r, phase_nxt;
  logic [8:0]           off_r, off_nxt;
  logic [SIZE_BITS-1:0] left_r, left_nxt;
  logic [8:0]           skip_r, skip_nxt;
  logic                 acc;
  logic                 hdr_en;
  logic [SIZE_BITS-1:0] size_now;
  hdr_sum_t             hs;
  logic                 emit;
  logic [1:0]           kind, etype;
  logic [2:0]           err;
  logic                 last;
  logic                 type_ok;
  logic [8:0]           size_lo;

  assign in_stall = out_valid & out_stall;
  assign acc      = in_valid & ~in_stall;
  assign hdr_en   = acc & ~in_op & (phase_r == PH_HEADER);

  tsp_header #(.SIZE_BITS(SIZE_BITS)) u_hdr (
    .clk      (clk),
    .rst_n    (rst_n),
    .hdr_en   (hdr_en),
    .offset   (off_r),
    .c        (in_in_byte),
    .size_now (size_now),
    .sum_now  (hs)
  );

  always_comb begin
    phase_nxt = phase_r;
    off_nxt   = off_r;
    left_nxt  = left_r;
    skip_nxt  = skip_r;
    emit      = 1'b0;
    kind      = KIND_DATA;
    err       = ERR_NONE;
    etype     = ET_FILE;
    last      = 1'b0;
    type_ok   = 1'b1;
    size_lo   = size_now[8:0];
    if (acc && (phase_r != PH_DONE) && (phase_r != PH_ERROR)) begin
      if (in_op) begin
        emit = 1'b1; kind = KIND_ERROR; err = ERR_TRUNC; phase_nxt = PH_ERROR;
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            off_nxt = off_r + 9'd1;
            if (off_r == 9'd511) begin
              off_nxt = 9'd0;
              emit = 1'b1;
              if (hs.type_byte == CH_ZERO || hs.type_byte == 8'd0) etype = ET_FILE;
              else if (hs.type_byte == CH_FIVE) etype = ET_DIR;
              else if (hs.type_byte == CH_TWO) etype = ET_SYMLINK;
              else type_ok = 1'b0;
              if (hs.all_zero) begin
                kind = KIND_END; phase_nxt = PH_DONE;
              end else if (!hs.sum_ok) begin
                kind = KIND_ERROR; err = ERR_CHECKSUM; phase_nxt = PH_ERROR;
              end else if (hs.unsafe) begin
                kind = KIND_ERROR; err = ERR_PATH; phase_nxt = PH_ERROR;
              end else if (!type_ok) begin
                kind = KIND_ERROR; err = ERR_TYPE; phase_nxt = PH_ERROR;
              end else begin
                kind = KIND_HEADER;
                if ((etype != ET_SYMLINK) && (size_now != '0)) begin
                  left_nxt  = size_now;
                  skip_nxt  = 9'd0 - size_lo;
                  phase_nxt = (etype == ET_FILE) ? PH_FILE : PH_DIR;
                end
              end
            end
          end
          PH_FILE, PH_DIR: begin
            emit = (phase_r == PH_FILE);
            last = (left_r == SIZE_BITS'(1));
            left_nxt = left_r - SIZE_BITS'(1);
            if (last) begin
              phase_nxt = (skip_r != 9'd0) ? PH_PAD : PH_HEADER;
              off_nxt = 9'd0;
            end
          end
          PH_PAD: begin
            skip_nxt = skip_r - 9'd1;
            if (skip_r == 9'd1) begin
              phase_nxt = PH_HEADER; off_nxt = 9'd0;
            end
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      off_r     <= '0;
      left_r    <= '0;
      skip_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      off_r   <= off_nxt;
      left_r  <= left_nxt;
      skip_r  <= skip_nxt;
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind         <= kind;
      out_out_byte     <= (kind == KIND_DATA) ? in_in_byte : 8'd0;
      out_last_of_file <= last;
      out_entry_type   <= (kind == KIND_HEADER) ? etype : ET_FILE;
      out_entry_size   <= (kind == KIND_HEADER) ? OUT_SIZE_W'(size_now) : '0;
      out_entry_mode   <= (kind == KIND_HEADER) ? hs.mode : 12'd0;
      out_error_code   <= err;
    end
  end

endmodule
`default_nettype wire

[rtl/tsp_header.sv]
`default_nettype none
module tsp_header
  import tsp_pkg::*;
#(
  parameter int SIZE_BITS = 36
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 hdr_en,
  input  wire logic [8:0]           offset,
  input  wire logic [7:0]           c,
  output logic [SIZE_BITS-1:0]      size_now,
  output hdr_sum_t                  sum_now
);

  logic [16:0]          sum_acc_r, sum_acc_nxt;
  logic [23:0]          stored_r, stored_nxt;
  logic [SIZE_BITS-1:0] size_r, size_nxt;
  logic [11:0]          mode_r, mode_nxt;
  logic [1:0]           oct_r, oct_nxt;
  logic                 zero_r, zero_nxt;
  logic [7:0]           type_r, type_nxt;
  path_flags_t          pf_r, pf_nxt;
  logic [15:0]          lb_r, lb_nxt;

  logic in_name, in_mode, in_size, in_sum, in_pre, is_oct, oct_digit;
  logic [2:0] dig;
  logic [1:0] oct_base;
  logic [16:0] sum_base;
  logic [23:0] stored_base;
  logic [SIZE_BITS-1:0] size_base;
  logic [11:0] mode_base;
  logic zero_base;
  path_flags_t pf_base;
  logic [15:0] lb_base;
  logic first;

  always_comb begin
    first       = (offset == 9'd0);
    in_name     = (offset < 9'd100);
    in_mode     = (offset >= 9'd100) && (offset < 9'd108);
    in_size     = (offset >= 9'd124) && (offset < 9'd136);
    in_sum      = (offset >= 9'd148) && (offset < 9'd156);
    in_pre      = (offset >= 9'd345) && (offset < 9'd500);
    dig         = c[2:0];
    oct_digit   = (c >= CH_ZERO) && (c <= CH_SEVEN);

    // Offset zero starts a fresh header.
    sum_base    = first ? 17'd0 : sum_acc_r;
    stored_base = first ? 24'd0 : stored_r;
    size_base   = first ? '0 : size_r;
    mode_base   = first ? 12'd0 : mode_r;
    zero_base   = first ? 1'b1 : zero_r;
    pf_base     = first ? '0 : pf_r;
    lb_base     = first ? {CH_SLASH, CH_SLASH} : lb_r;
    type_nxt    = first ? 8'd0 : type_r;
    oct_base    = ((offset == 9'd100) || (offset == 9'd124) || (offset == 9'd148))
                  ? 2'd0 : oct_r;

    zero_nxt    = zero_base & (c == 8'd0);
    sum_acc_nxt = sum_base + (in_sum ? 17'(CH_SPACE) : 17'(c));

    // Lenient octal: skip leading spaces, stop at the first non-digit.
    oct_nxt     = oct_base;
    is_oct      = 1'b0;
    if (!oct_base[1]) begin
      if (oct_base[0] || (c != CH_SPACE)) begin
        oct_nxt[0] = 1'b1;
        if (oct_digit) is_oct = 1'b1;
        else oct_nxt[1] = 1'b1;
      end
    end
    if (!(in_mode || in_size || in_sum)) oct_nxt = oct_base;

    stored_nxt = stored_base;
    size_nxt   = size_base;
    mode_nxt   = mode_base;
    if (in_mode && is_oct) mode_nxt = {mode_base[8:0], dig};
    if (in_size && is_oct) size_nxt = {size_base[SIZE_BITS-4:0], dig};
    if (in_sum && is_oct)  stored_nxt = {stored_base[20:0], dig};
    if (offset == 9'd156)  type_nxt = c;

    pf_nxt = pf_base;
    lb_nxt = lb_base;
    if (in_name || in_pre) begin
      if ((offset == 9'd0) || (offset == 9'd345)) begin
        lb_nxt = {CH_SLASH, CH_SLASH};
        pf_nxt.slash3 = 1'b1;
        pf_nxt.ended = 1'b0;
        if (offset == 9'd0) begin
          if (c == 8'd0) pf_nxt.name_empty = 1'b1;
          if (c == CH_SLASH) pf_nxt.name_slash = 1'b1;
        end else begin
          if (c != 8'd0) pf_nxt.pre_set = 1'b1;
          if (c == CH_SLASH) pf_nxt.pre_slash = 1'b1;
        end
      end
      if (!pf_nxt.ended) begin
        if (c == 8'd0) begin
          if ((lb_nxt == {CH_DOT, CH_DOT}) && pf_nxt.slash3) pf_nxt.dotdot = 1'b1;
          pf_nxt.ended = 1'b1;
        end else begin
          if ((c == CH_SLASH) && (lb_nxt == {CH_DOT, CH_DOT}) && pf_nxt.slash3)
            pf_nxt.dotdot = 1'b1;
          pf_nxt.slash3 = (lb_nxt[15:8] == CH_SLASH);
          lb_nxt = {lb_nxt[7:0], c};
          if (((offset == 9'd99) || (offset == 9'd499)) &&
              (lb_nxt == {CH_DOT, CH_DOT}) && pf_nxt.slash3)
            pf_nxt.dotdot = 1'b1;
        end
      end
    end

    size_now = size_nxt;
    sum_now.all_zero  = zero_nxt;
    sum_now.sum_ok    = ({7'd0, sum_acc_nxt} == stored_nxt);
    sum_now.unsafe    = (pf_nxt.pre_set ? pf_nxt.pre_slash
                         : (pf_nxt.name_empty | pf_nxt.name_slash)) | pf_nxt.dotdot;
    sum_now.type_byte = type_nxt;
    sum_now.mode      = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_acc_r <= '0;
      stored_r  <= '0;
      size_r    <= '0;
      mode_r    <= '0;
      oct_r     <= '0;
      zero_r    <= 1'b1;
      type_r    <= '0;
      pf_r      <= '0;
      lb_r      <= {CH_SLASH, CH_SLASH};
    end else if (hdr_en) begin
      sum_acc_r <= sum_acc_nxt;
      stored_r  <= stored_nxt;
      size_r    <= size_nxt;
      mode_r    <= mode_nxt;
      oct_r     <= oct_nxt;
      zero_r    <= zero_nxt;
      type_r    <= type_nxt;
      pf_r      <= pf_nxt;
      lb_r      <= lb_nxt;
    end
  end

endmodule
`default_nettype wire
